FILE: sv/cmb_pkg.sv
package cmb_pkg;

    // sizing of the point store and the coordinate format
    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;

    // fixed field widths
    localparam int STAMP_W  = 32;
    localparam int POS_W    = 16;
    localparam int ROW_W    = 64;
    localparam int RIDX_W   = 6;
    localparam int PC_W     = 7;
    localparam int THR_W    = 36;

    // derived widths
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = THR_W;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_THRESHOLD = 1'b1;
    localparam logic [PC_W-1:0] PC_RESET = PC_W'(MAX_POINTS);

    // result status codes
    localparam logic STATUS_ROW   = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef struct packed {
        logic [STAMP_W-1:0]      stamp;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic [STAMP_W-1:0] frame_stamp;
        logic [RIDX_W-1:0]  row_index;
        logic [ROW_W-1:0]   row_bits;
        logic               status;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_point;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_DRAIN
    } t_state;

endpackage

FILE: sv/cmb_cell.sv
module cmb_cell (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic                      i_adv,
    input  cmb_pkg::t_point           i_pt,
    output cmb_pkg::t_point           o_pt,
    input  cmb_pkg::t_point           i_probe,
    input  logic [cmb_pkg::THR_W-1:0] i_thr,
    output logic                      o_hit
);

    cmb_pkg::t_point r_pt;
    logic [cmb_pkg::SQ_W-1:0] r_sq_x;
    logic [cmb_pkg::SQ_W-1:0] r_sq_y;
    logic [cmb_pkg::SQ_W-1:0] r_sq_z;
    logic r_hit;

    logic signed [cmb_pkg::DIFF_W-1:0]   w_dx;
    logic signed [cmb_pkg::DIFF_W-1:0]   w_dy;
    logic signed [cmb_pkg::DIFF_W-1:0]   w_dz;
    logic signed [2*cmb_pkg::DIFF_W-1:0] w_px;
    logic signed [2*cmb_pkg::DIFF_W-1:0] w_py;
    logic signed [2*cmb_pkg::DIFF_W-1:0] w_pz;
    logic [cmb_pkg::SUM_W-1:0]           w_sum;

    // differences to the probe point and their squares
    always_comb begin
        w_dx = cmb_pkg::DIFF_W'(i_probe.x) - cmb_pkg::DIFF_W'(r_pt.x);
        w_dy = cmb_pkg::DIFF_W'(i_probe.y) - cmb_pkg::DIFF_W'(r_pt.y);
        w_dz = cmb_pkg::DIFF_W'(i_probe.z) - cmb_pkg::DIFF_W'(r_pt.z);
        w_px = w_dx * w_dx;
        w_py = w_dy * w_dy;
        w_pz = w_dz * w_dz;
    end

    // sum of squares from the registered products
    assign w_sum = cmb_pkg::SUM_W'(r_sq_x) + cmb_pkg::SUM_W'(r_sq_y)
                 + cmb_pkg::SUM_W'(r_sq_z);

    // own point shifts along the chain on a load
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pt <= i_pt;
        end
    end

    // two compare stages, frozen together with the row pipeline
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sq_x <= w_px[cmb_pkg::SQ_W-1:0];
            r_sq_y <= w_py[cmb_pkg::SQ_W-1:0];
            r_sq_z <= w_pz[cmb_pkg::SQ_W-1:0];
            r_hit  <= cmb_pkg::CMP_W'(w_sum) < cmb_pkg::CMP_W'(i_thr);
        end
    end

    assign o_pt  = r_pt;
    assign o_hit = r_hit;

endmodule

FILE: sv/cmb_chain.sv
module cmb_chain (
    input  logic                           i_clk,
    input  logic                           i_load,
    input  logic                           i_adv,
    input  cmb_pkg::t_point                i_new_pt,
    input  cmb_pkg::t_point                i_probe,
    input  logic [cmb_pkg::THR_W-1:0]      i_thr,
    input  logic [cmb_pkg::CNT_W-1:0]      i_shift,
    output logic [cmb_pkg::MAX_POINTS-1:0] o_row_bits
);

    cmb_pkg::t_point w_pt [cmb_pkg::MAX_POINTS];
    logic [cmb_pkg::MAX_POINTS-1:0] w_hit;

    // row of cells, new points enter at the top cell and move down
    for (genvar g = 0; g < cmb_pkg::MAX_POINTS; g++) begin : g_cell
        cmb_pkg::t_point w_in;
        if (g == cmb_pkg::MAX_POINTS - 1) begin : g_top
            assign w_in = i_new_pt;
        end else begin : g_mid
            assign w_in = w_pt[g+1];
        end
        cmb_cell u_cell (
            .i_clk   (i_clk),
            .i_load  (i_load),
            .i_adv   (i_adv),
            .i_pt    (w_in),
            .o_pt    (w_pt[g]),
            .i_probe (i_probe),
            .i_thr   (i_thr),
            .o_hit   (w_hit[g])
        );
    end

    // point k of an n-point frame sits in cell MAX_POINTS-n+k
    assign o_row_bits = w_hit >> i_shift;

endmodule

FILE: sv/contact_map_builder_unit.sv
// Contact map builder. Points arrive one per transfer and are taken one per
// cycle while no frame is being emitted and the output is not stalled. When
// the point that fills the frame is taken, the block emits one row per held
// point, one row per cycle while the output is not stalled, through four row
// pipeline stages (store read, squaring stage, threshold compare stage,
// output register); the frame's points sit in a row of compare cells that
// evaluate a whole row at once. Input is held off during emission. A stamp
// change in an unfinished frame yields one error result; the new point opens
// a new frame. The user must write configuration while idle; it is unchecked.
module contact_map_builder_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  cmb_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output cmb_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [cmb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cmb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    cmb_pkg::t_state r_state;
    cmb_pkg::t_state n_state;

    logic [cmb_pkg::PC_W-1:0]    r_point_count;
    logic [cmb_pkg::THR_W-1:0]   r_thr;
    logic [cmb_pkg::CNT_W-1:0]   r_held;
    logic [cmb_pkg::STAMP_W-1:0] r_cur_stamp;
    logic [cmb_pkg::CNT_W-1:0]   r_rows;
    logic [cmb_pkg::CNT_W-1:0]   r_shift;
    logic [cmb_pkg::IDX_W-1:0]   r_row_j;

    cmb_pkg::t_point r_mem [cmb_pkg::MAX_POINTS];
    cmb_pkg::t_point r_probe;

    logic                      r_p1_valid;
    logic                      r_p2_valid;
    logic                      r_p3_valid;
    logic [cmb_pkg::IDX_W-1:0] r_p1_idx;
    logic [cmb_pkg::IDX_W-1:0] r_p2_idx;
    logic [cmb_pkg::IDX_W-1:0] r_p3_idx;
    logic                      r_p1_last;
    logic                      r_p2_last;
    logic                      r_p3_last;

    logic               r_out_valid;
    cmb_pkg::t_out_item r_out;

    logic                           w_adv;
    logic                           w_accept;
    logic                           w_issue;
    logic                           w_stall;
    logic                           w_stamp_err;
    logic                           w_complete;
    logic                           w_last_issue;
    logic [cmb_pkg::PC_W-1:0]       w_frame_size;
    logic [cmb_pkg::CNT_W-1:0]      w_base;
    logic [cmb_pkg::CNT_W-1:0]      w_new_held;
    cmb_pkg::t_point                w_new_pt;
    logic [cmb_pkg::MAX_POINTS-1:0] w_row_bits;

    // output register is free or being emptied this cycle
    assign w_adv    = !r_out_valid || !i_out_stall;
    assign w_accept = i_in_valid && !w_stall;

    // frame size with out-of-range counts clamped
    always_comb begin
        priority if (r_point_count == '0) begin
            w_frame_size = cmb_pkg::PC_W'(1);
        end else if (r_point_count > cmb_pkg::PC_W'(cmb_pkg::MAX_POINTS)) begin
            w_frame_size = cmb_pkg::PC_W'(cmb_pkg::MAX_POINTS);
        end else begin
            w_frame_size = r_point_count;
        end
    end

    // frame bookkeeping for an incoming point
    assign w_stamp_err  = (r_held != '0) && (i_in_data.stamp != r_cur_stamp);
    assign w_base       = w_stamp_err ? '0 : r_held;
    assign w_new_held   = w_base + cmb_pkg::CNT_W'(1);
    assign w_complete   = cmb_pkg::PC_W'(w_new_held) >= w_frame_size;
    assign w_last_issue = (cmb_pkg::CNT_W'(r_row_j) + cmb_pkg::CNT_W'(1)) == r_rows;

    assign w_new_pt.x = i_in_data.pos_x[cmb_pkg::COORD_BITS-1:0];
    assign w_new_pt.y = i_in_data.pos_y[cmb_pkg::COORD_BITS-1:0];
    assign w_new_pt.z = i_in_data.pos_z[cmb_pkg::COORD_BITS-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cmb_pkg::ST_IDLE: begin
                if (w_accept && w_complete) begin
                    n_state = cmb_pkg::ST_EMIT;
                end
            end
            cmb_pkg::ST_EMIT: begin
                if (w_issue && w_last_issue) begin
                    n_state = cmb_pkg::ST_DRAIN;
                end
            end
            cmb_pkg::ST_DRAIN: begin
                if (!r_p1_valid && !r_p2_valid && !r_p3_valid) begin
                    n_state = cmb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cmb_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        w_issue = 1'b0;
        w_stall = 1'b1;
        unique case (r_state)
            cmb_pkg::ST_IDLE: begin
                w_stall = !w_adv;
            end
            cmb_pkg::ST_EMIT: begin
                w_issue = w_adv;
            end
            cmb_pkg::ST_DRAIN: begin
                w_stall = 1'b1;
            end
            default: begin
                w_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= cmb_pkg::PC_RESET;
            r_thr         <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cmb_pkg::CFG_POINT_COUNT: begin
                    r_point_count <= i_cfg_data[cmb_pkg::PC_W-1:0];
                end
                cmb_pkg::CFG_DIST_THRESHOLD: begin
                    r_thr <= i_cfg_data[cmb_pkg::THR_W-1:0];
                end
                default: begin
                    r_thr <= r_thr;
                end
            endcase
        end
    end

    // frame fill count and stamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_cur_stamp <= '0;
        end else if (w_accept) begin
            r_held <= w_complete ? '0 : w_new_held;
            if (w_base == '0) begin
                r_cur_stamp <= i_in_data.stamp;
            end
        end
    end

    // row sequencing for a completed frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_j <= '0;
            r_rows  <= '0;
            r_shift <= '0;
        end else if (w_accept && w_complete) begin
            r_row_j <= '0;
            r_rows  <= w_new_held;
            r_shift <= cmb_pkg::CNT_W'(cmb_pkg::MAX_POINTS) - w_new_held;
        end else if (w_issue) begin
            r_row_j <= r_row_j + cmb_pkg::IDX_W'(1);
        end
    end

    // point store, read once per row to give the probe point
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[w_base[cmb_pkg::IDX_W-1:0]] <= w_new_pt;
        end
        if (w_issue) begin
            r_probe <= r_mem[r_row_j];
        end
    end

    // row pipeline tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else if (w_adv) begin
            r_p1_valid <= w_issue;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_idx  <= r_row_j;
            r_p1_last <= w_last_issue;
            r_p2_idx  <= r_p1_idx;
            r_p2_last <= r_p1_last;
            r_p3_idx  <= r_p2_idx;
            r_p3_last <= r_p2_last;
        end
    end

    // compare cells
    cmb_chain u_chain (
        .i_clk      (i_clk),
        .i_load     (w_accept),
        .i_adv      (w_adv),
        .i_new_pt   (w_new_pt),
        .i_probe    (r_probe),
        .i_thr      (r_thr),
        .i_shift    (r_shift),
        .o_row_bits (w_row_bits)
    );

    // output register, error result or finished row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= (w_accept && w_stamp_err) || r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_accept && w_stamp_err) begin
                r_out.frame_stamp <= r_cur_stamp;
                r_out.row_index   <= '0;
                r_out.row_bits    <= '0;
                r_out.status      <= cmb_pkg::STATUS_ERROR;
                r_out.last        <= !w_complete;
            end else if (r_p3_valid) begin
                r_out.frame_stamp <= r_cur_stamp;
                r_out.row_index   <= cmb_pkg::RIDX_W'(r_p3_idx);
                r_out.row_bits    <= cmb_pkg::ROW_W'(w_row_bits);
                r_out.status      <= cmb_pkg::STATUS_ROW;
                r_out.last        <= r_p3_last;
            end
        end
    end

    assign o_in_stall  = w_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: sim/cmb_checker.sv
`timescale 1ns / 100ps

module cmb_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  cmb_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  cmb_pkg::t_out_item             i_out_data,
    input  logic                           i_cfg_we,
    input  logic [cmb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cmb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import cmb_pkg::*;

    // shadow copy of the point store and frame tracking
    logic signed [COORD_BITS-1:0] pt_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] pt_y [MAX_POINTS];
    logic signed [COORD_BITS-1:0] pt_z [MAX_POINTS];
    int                           held_cnt;
    logic [STAMP_W-1:0]           open_stamp;

    // shadow copy of the registers
    logic [PC_W-1:0]              cfg_points;
    logic [THR_W-1:0]             cfg_thresh;

    // rows and error results still to come out of the block
    t_out_item                    rows_due [$];
    int                           fails;

    initial begin
        fails        = 0;
        held_cnt     = 0;
        open_stamp   = '0;
        cfg_points   = PC_RESET;
        cfg_thresh   = '0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
        fails++;
    endtask

    // squared distance between two held points
    function automatic logic [63:0] sq_span(input int a, input int b);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(pt_x[a]) - longint'(pt_x[b]);
        dy = longint'(pt_y[a]) - longint'(pt_y[b]);
        dz = longint'(pt_z[a]) - longint'(pt_z[b]);
        return 64'(dx * dx + dy * dy + dz * dz);
    endfunction

    // store one point and queue the results it causes
    task automatic take_point(input t_in_item item);
        t_out_item  r;
        int         first;
        int         frame_len;
        logic [ROW_W-1:0] bits;
        first = rows_due.size();
        // stamp change in an unfinished frame drops it with an error
        if (held_cnt > 0 && item.stamp != open_stamp) begin
            r = '0;
            r.frame_stamp = open_stamp;
            r.status = STATUS_ERROR;
            rows_due.push_back(r);
            held_cnt = 0;
        end
        if (held_cnt == 0)
            open_stamp = item.stamp;
        if (held_cnt < MAX_POINTS) begin
            pt_x[held_cnt] = item.pos_x[COORD_BITS-1:0];
            pt_y[held_cnt] = item.pos_y[COORD_BITS-1:0];
            pt_z[held_cnt] = item.pos_z[COORD_BITS-1:0];
            held_cnt++;
        end
        // out of range counts clamp to 1..MAX_POINTS
        if (cfg_points == 0)
            frame_len = 1;
        else if (int'(cfg_points) > MAX_POINTS)
            frame_len = MAX_POINTS;
        else
            frame_len = int'(cfg_points);
        // full frame: one contact row per held point
        if (held_cnt >= frame_len) begin
            for (int j = 0; j < held_cnt; j++) begin
                bits = '0;
                for (int k = 0; k < held_cnt; k++) begin
                    if (sq_span(j, k) < 64'(cfg_thresh))
                        bits[k] = 1'b1;
                end
                r = '0;
                r.frame_stamp = open_stamp;
                r.row_index = RIDX_W'(j);
                r.row_bits = bits;
                r.status = STATUS_ROW;
                rows_due.push_back(r);
            end
            held_cnt = 0;
        end
        // flag the final result of this point
        if (rows_due.size() > first) begin
            r = rows_due.pop_back();
            r.last = 1'b1;
            rows_due.push_back(r);
        end
    endtask

    // compare one result transfer with the oldest expected one
    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (rows_due.size() == 0) begin
            report_mismatch("result with nothing pending", 64'(got.row_index), 64'd0);
        end else begin
            want = rows_due.pop_front();
            if (got.frame_stamp !== want.frame_stamp)
                report_mismatch("frame_stamp", 64'(got.frame_stamp), 64'(want.frame_stamp));
            if (got.row_index !== want.row_index)
                report_mismatch("row_index", 64'(got.row_index), 64'(want.row_index));
            if (got.row_bits !== want.row_bits)
                report_mismatch("row_bits", got.row_bits, want.row_bits);
            if (got.status !== want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.last !== want.last)
                report_mismatch("last", 64'(got.last), 64'(want.last));
        end
    endtask

    // watch both channels and the register port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_cnt   = 0;
            open_stamp = '0;
            cfg_points = PC_RESET;
            cfg_thresh = '0;
        end else begin
            if (i_out_valid && !i_out_stall)
                check_result(i_out_data);
            if (i_in_valid && !i_in_stall)
                take_point(i_in_data);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POINT_COUNT: begin
                        cfg_points = i_cfg_data[PC_W-1:0];
                    end
                    CFG_DIST_THRESHOLD: begin
                        cfg_thresh = i_cfg_data[THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending    <= rows_due.size();
        o_fail_count <= fails;
    end

endmodule

FILE: sim/tb_contact_map_builder_unit.sv
`timescale 1ns / 100ps

module tb_contact_map_builder_unit;
    import cmb_pkg::*;

    localparam int RAND_ITEMS = 400;
    localparam int TAIL_CYCLES = 2 * MAX_POINTS + 16;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    bit                    idle_on;

    contact_map_builder_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    cmb_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

    // receiver stalls in random bursts
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // one point transfer, with an occasional gap in front
    task automatic send_point(input logic [STAMP_W-1:0] stamp, input logic [POS_W-1:0] x,
                              input logic [POS_W-1:0] y, input logic [POS_W-1:0] z);
        t_in_item item;
        item.stamp = stamp;
        item.pos_x = x;
        item.pos_y = y;
        item.pos_z = z;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // hold off input until every pending result is out, then let the store settle
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // coordinate either anywhere or near a cluster center
    function automatic logic [POS_W-1:0] pick_coord(input bit spread,
                                                     input logic [POS_W-1:0] base);
        if (spread)
            return POS_W'($urandom);
        return base + POS_W'($urandom_range(0, 63)) - POS_W'(32);
    endfunction

    initial begin : stimulus
        int               sent;
        int               frames;
        int               eff;
        int               k;
        int               f;
        int               p;
        bit               spread;
        bit               noisy;
        logic [PC_W-1:0]  pc;
        logic [THR_W-1:0] thr;
        logic [STAMP_W-1:0] stamp;
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
        logic [POS_W-1:0] cz;

        in_valid <= 1'b0;
        in_data  <= '0;
        cfg_we   <= 1'b0;
        cfg_idx  <= '0;
        cfg_data <= '0;
        idle_on = 1'b0;
        rst_n   <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n   <= 1'b1;
        idle_on = 1'b1;

        // single point frame, coordinate extremes, zero threshold sets nothing
        cfg_write(CFG_POINT_COUNT, CFG_DATA_W'(1));
        cfg_write(CFG_DIST_THRESHOLD, '0);
        send_point(32'h0, 16'h8000, 16'h7FFF, 16'h0000);

        // widest spread under the largest threshold, top stamp
        settle();
        cfg_write(CFG_POINT_COUNT, CFG_DATA_W'(2));
        cfg_write(CFG_DIST_THRESHOLD, CFG_DATA_W'(36'hF_FFFF_FFFF));
        send_point(32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h8000);
        send_point(32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);

        // distance equal to the threshold is no contact
        settle();
        cfg_write(CFG_DIST_THRESHOLD, CFG_DATA_W'(25));
        send_point(32'd1, 16'd0, 16'd0, 16'd0);
        send_point(32'd1, 16'd3, 16'd4, 16'd0);

        // stamp change partway through a frame
        settle();
        cfg_write(CFG_POINT_COUNT, CFG_DATA_W'(3));
        cfg_write(CFG_DIST_THRESHOLD, CFG_DATA_W'(1000));
        send_point(32'd5, 16'd10, 16'd10, 16'd10);
        send_point(32'd5, 16'd12, 16'd10, 16'd10);
        send_point(32'd6, 16'd0, 16'd0, 16'd0);
        send_point(32'd6, 16'd1, 16'd1, 16'd1);
        send_point(32'd6, 16'hFF9C, 16'd0, 16'd0);

        // error followed at once by a complete new frame
        settle();
        cfg_write(CFG_POINT_COUNT, CFG_DATA_W'(4));
        send_point(32'd9, 16'd1, 16'd2, 16'd3);
        send_point(32'd9, 16'd4, 16'd5, 16'd6);
        settle();
        cfg_write(CFG_POINT_COUNT, CFG_DATA_W'(1));
        send_point(32'd10, 16'd7, 16'd8, 16'd9);

        // count lowered while a frame is open
        settle();
        cfg_write(CFG_POINT_COUNT, CFG_DATA_W'(4));
        send_point(32'd11, 16'd0, 16'd0, 16'd0);
        send_point(32'd11, 16'd5, 16'd0, 16'd0);
        send_point(32'd11, 16'd0, 16'd30, 16'd0);
        settle();
        cfg_write(CFG_POINT_COUNT, CFG_DATA_W'(2));
        send_point(32'd11, 16'd0, 16'd0, 16'd20);

        // zero count acts as one
        settle();
        cfg_write(CFG_POINT_COUNT, CFG_DATA_W'(0));
        send_point(32'd12, 16'd5, 16'd5, 16'd5);

        // random phases, each with its own register setting
        sent = 0;
        while (sent < RAND_ITEMS) begin
            settle();
            // a phase sends at most 2 * MAX_POINTS points, so the tail phases run without gaps
            if (sent > RAND_ITEMS - 2 * MAX_POINTS - 2)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 15))
                0: pc = '0;
                1: pc = PC_W'($urandom_range(MAX_POINTS + 1, 127));
                2: pc = PC_W'(MAX_POINTS);
                3: pc = PC_W'(1);
                default: pc = PC_W'($urandom_range(2, 8));
            endcase
            if (pc == 0)
                eff = 1;
            else if (int'(pc) > MAX_POINTS)
                eff = MAX_POINTS;
            else
                eff = int'(pc);
            spread = ($urandom_range(0, 2) == 0);
            noisy  = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 5))
                0: thr = '0;
                1: thr = '1;
                default: begin
                    if (spread)
                        thr = THR_W'({$urandom, $urandom}) >> $urandom_range(0, 6);
                    else
                        thr = THR_W'($urandom_range(0, 6000));
                end
            endcase
            cfg_write(CFG_POINT_COUNT, CFG_DATA_W'(pc));
            cfg_write(CFG_DIST_THRESHOLD, CFG_DATA_W'(thr));
            cx = POS_W'($urandom);
            cy = POS_W'($urandom);
            cz = POS_W'($urandom);

            // whole frames, now and then broken by a stamp change
            frames = (eff > 16) ? 1 : $urandom_range(1, 6);
            for (f = 0; f < frames; f++) begin
                stamp = $urandom;
                for (p = 0; p < eff; p++) begin
                    if (noisy)
                        stamp = STAMP_W'($urandom_range(0, 1));
                    else if ($urandom_range(0, 15) == 0)
                        stamp = $urandom;
                    send_point(stamp, pick_coord(spread, cx), pick_coord(spread, cy),
                               pick_coord(spread, cz));
                    sent++;
                end
            end

            // partial frame, then a smaller count before its last point
            if (eff >= 2 && $urandom_range(0, 4) == 0) begin
                stamp = $urandom;
                k = $urandom_range(1, eff - 1);
                repeat (k) begin
                    send_point(stamp, pick_coord(spread, cx), pick_coord(spread, cy),
                               pick_coord(spread, cz));
                    sent++;
                end
                settle();
                cfg_write(CFG_POINT_COUNT, CFG_DATA_W'($urandom_range(1, k)));
                send_point(stamp, pick_coord(spread, cx), pick_coord(spread, cy),
                           pick_coord(spread, cz));
                sent++;
            end
        end

        // drain and give the verdict
        idle_on = 1'b0;
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
sv/cmb_pkg.sv
sv/cmb_cell.sv
sv/cmb_chain.sv
sv/contact_map_builder_unit.sv
sim/cmb_checker.sv
sim/tb_contact_map_builder_unit.sv
